// ----- design/sst_pkg.sv -----
// Shared types, codes and helper functions of the source tokenizer
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;

    localparam int unsigned SRC_OFS_MAX_DEF = 65535;
    localparam int unsigned LINE_MAX_DEF    = 65535;
    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam int unsigned NUM_KEYS        = 13;
    localparam int unsigned MAX_TOKS        = 3;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum logic [5:0] {
        K_LPAREN, K_RPAREN, K_LBRACK, K_RBRACK, K_LBRACE, K_RBRACE, K_DOT, K_COMMA,
        K_COLON, K_SEMI, K_PLUS, K_PLUS_EQ, K_MINUS, K_MINUS_EQ, K_STAR, K_STAR_EQ,
        K_SLASH, K_SLASH_EQ, K_PERCENT, K_PERCENT_EQ, K_TILDE, K_BANG, K_BANG_EQ,
        K_AMP, K_AMP_AMP, K_AMP_EQ, K_PIPE, K_PIPE_PIPE, K_PIPE_EQ, K_CARET,
        K_CARET_EQ, K_LT, K_LE, K_SHL, K_SHL_EQ, K_GT, K_GE, K_SHR, K_SHR_EQ,
        K_ASSIGN, K_EQ, K_QUESTION, K_STRING, K_NUMBER, K_IDENT,
        K_LET, K_IF, K_ELSE, K_TRUE, K_FALSE, K_NIL, K_WHILE, K_FOR, K_FN,
        K_FIELD, K_RETURN, K_STATIC, K_CONST, K_END
    } t_kind;

    typedef enum logic [1:0] {
        E_OK, E_UNTERM_STRING, E_NUMBER_DOT, E_UNKNOWN_CHAR
    } t_err;

    typedef enum logic [3:0] {
        M_IDLE, M_OPER, M_NUMI, M_NUMD, M_NUMF, M_WORD, M_STR, M_LCOM, M_BCOM,
        M_BSTAR, M_DROP
    } t_mode;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_source;
    } t_in;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic [1:0]  error_code;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic [1:0]                count;
        t_out [MAX_TOKS-1:0]       toks;
    } t_bundle;

    typedef struct packed {
        logic valid;
        t_kind kind;
    } t_pair;

    localparam logic [47:0] KEY_TEXT [NUM_KEYS] = '{
        "let", "if", "else", "true", "false", "nil", "while",
        "for", "fn", "field", "return", "static", "const"
    };
    localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{
        3'd3, 3'd2, 3'd4, 3'd4, 3'd5, 3'd3, 3'd5, 3'd3, 3'd2, 3'd5, 3'd6, 3'd6, 3'd5
    };

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic logic [NUM_KEYS-1:0] key_match(input logic [2:0] wl,
                                                      input logic [7:0] c);
        logic [NUM_KEYS-1:0] m;
        m = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (wl < KEY_LEN[k] &&
                KEY_TEXT[k][8*(int'(KEY_LEN[k]) - 1 - int'(wl)) +: 8] == c)
                m[k] = 1'b1;
        end
        return m;
    endfunction

    function automatic t_kind word_kind(input logic [NUM_KEYS-1:0] cand,
                                        input logic [2:0] wl);
        t_kind r;
        r = K_IDENT;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (cand[k] && KEY_LEN[k] == wl)
                r = t_kind'(6'(int'(K_LET) + k));
        end
        return r;
    endfunction

    function automatic t_kind single_kind(input logic [7:0] p);
        case (p)
            "+": return K_PLUS;
            "-": return K_MINUS;
            "*": return K_STAR;
            "/": return K_SLASH;
            "%": return K_PERCENT;
            "!": return K_BANG;
            "&": return K_AMP;
            "|": return K_PIPE;
            "^": return K_CARET;
            "<": return K_LT;
            "L": return K_SHL;
            ">": return K_GT;
            "G": return K_SHR;
            default: return K_ASSIGN;
        endcase
    endfunction

    function automatic t_pair pair_kind(input logic [7:0] p, input logic [7:0] b);
        t_pair r;
        r.valid = 1'b1;
        r.kind  = t_kind'(6'(int'(single_kind(p)) + 1));
        if (p == "&" && b == "&")      r.kind = K_AMP_AMP;
        else if (p == "|" && b == "|") r.kind = K_PIPE_PIPE;
        else if (b != "=")             r.valid = 1'b0;
        else if (p == "&")             r.kind = K_AMP_EQ;
        else if (p == "|")             r.kind = K_PIPE_EQ;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/sst_front.sv -----
// Scanner front end: one source byte per transaction into a bundle of up to three tokens
`timescale 1ns / 1ps
`default_nettype none
module sst_front #(
    parameter int unsigned SOURCE_OFFSET_MAX = sst_pkg::SRC_OFS_MAX_DEF,
    parameter int unsigned LINE_COUNT_MAX    = sst_pkg::LINE_MAX_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  sst_pkg::t_in     i_data,
    output logic             o_ready,
    input  wire              i_q_full,
    output logic             o_push,
    output sst_pkg::t_bundle o_bundle
);
    localparam int unsigned OW = $clog2(SOURCE_OFFSET_MAX + 1);
    localparam int unsigned LW = $clog2(LINE_COUNT_MAX + 1);
    localparam logic [OW-1:0] OFS_MAX = OW'(SOURCE_OFFSET_MAX);
    localparam logic [LW-1:0] LN_MAX  = LW'(LINE_COUNT_MAX);

    sst_pkg::t_mode                 r_mode, n_mode;
    logic [7:0]                     r_pend, n_pend;
    logic [OW-1:0]                  r_so, n_so;
    logic [OW-1:0]                  r_ofs, n_ofs;
    logic [LW-1:0]                  r_line, n_line;
    logic [2:0]                     r_wl, n_wl;
    logic [sst_pkg::NUM_KEYS-1:0]   r_cand, n_cand;
    logic                           accept;

    function automatic logic [OW-1:0] ofs_inc(input logic [OW-1:0] v);
        return (v < OFS_MAX) ? OW'(v + 1'b1) : OFS_MAX;
    endfunction

    function automatic logic [LW-1:0] line_inc(input logic [LW-1:0] v);
        return (v < LN_MAX) ? LW'(v + 1'b1) : LN_MAX;
    endfunction

    function automatic sst_pkg::t_out mk(input sst_pkg::t_kind k, input logic [OW-1:0] s,
                                         input logic [OW-1:0] e, input logic [LW-1:0] ln,
                                         input sst_pkg::t_err er);
        sst_pkg::t_out t;
        t.token_kind   = k;
        t.token_start  = 16'(s);
        t.token_length = (e >= s) ? 16'(e - s) : 16'd0;
        t.line_number  = 16'(ln);
        t.error_code   = er;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    always_comb begin
        logic [7:0]    b;
        logic [OW-1:0] pos, end1;
        logic          redo, ended;
        logic [1:0]    cnt;
        sst_pkg::t_pair pk;
        sst_pkg::t_kind ik;
        logic          ik_ok;

        b      = i_data.source_byte;
        pos    = r_ofs;
        end1   = ofs_inc(r_ofs);
        n_mode = r_mode;
        n_pend = r_pend;
        n_so   = r_so;
        n_line = r_line;
        n_wl   = r_wl;
        n_cand = r_cand;
        n_ofs  = end1;
        redo   = 1'b0;
        ended  = 1'b0;
        cnt    = 2'd0;
        ik     = sst_pkg::K_END;
        ik_ok  = 1'b0;
        o_bundle = '0;
        pk     = sst_pkg::pair_kind(r_pend, b);

        case (r_mode)
            sst_pkg::M_OPER: begin
                if (r_pend == "/" && b == "/") n_mode = sst_pkg::M_LCOM;
                else if (r_pend == "/" && b == "*") n_mode = sst_pkg::M_BCOM;
                else if (r_pend == "<" && b == "<") n_pend = "L";
                else if (r_pend == ">" && b == ">") n_pend = "G";
                else if (pk.valid) begin
                    o_bundle.toks[cnt] = mk(pk.kind, r_so, end1, n_line, sst_pkg::E_OK);
                    cnt = cnt + 2'd1;
                    n_mode = sst_pkg::M_IDLE;
                end else begin
                    o_bundle.toks[cnt] = mk(sst_pkg::single_kind(r_pend), r_so, pos, n_line,
                                            sst_pkg::E_OK);
                    cnt = cnt + 2'd1;
                    n_mode = sst_pkg::M_IDLE;
                    redo = 1'b1;
                end
            end
            sst_pkg::M_NUMI, sst_pkg::M_NUMF: begin
                if (sst_pkg::is_digit(b)) begin
                end else if (r_mode == sst_pkg::M_NUMI && b == ".") begin
                    n_mode = sst_pkg::M_NUMD;
                end else begin
                    o_bundle.toks[cnt] = mk(sst_pkg::K_NUMBER, r_so, pos, n_line,
                                            sst_pkg::E_OK);
                    cnt = cnt + 2'd1;
                    n_mode = sst_pkg::M_IDLE;
                    redo = 1'b1;
                end
            end
            sst_pkg::M_NUMD: begin
                if (sst_pkg::is_digit(b)) n_mode = sst_pkg::M_NUMF;
                else begin
                    o_bundle.toks[cnt] = mk(sst_pkg::K_END, r_so, pos, n_line,
                                            sst_pkg::E_NUMBER_DOT);
                    cnt = cnt + 2'd1;
                    n_mode = sst_pkg::M_DROP;
                end
            end
            sst_pkg::M_WORD: begin
                if (sst_pkg::is_letter(b) || sst_pkg::is_digit(b)) begin
                    n_cand = r_cand & sst_pkg::key_match(r_wl, b);
                    n_wl   = (r_wl < 3'd7) ? 3'(r_wl + 3'd1) : 3'd7;
                end else begin
                    o_bundle.toks[cnt] = mk(sst_pkg::word_kind(r_cand, r_wl), r_so, pos,
                                            n_line, sst_pkg::E_OK);
                    cnt = cnt + 2'd1;
                    n_mode = sst_pkg::M_IDLE;
                    redo = 1'b1;
                end
            end
            sst_pkg::M_STR: begin
                if (b == "\"") begin
                    o_bundle.toks[cnt] = mk(sst_pkg::K_STRING, ofs_inc(r_so), pos, n_line,
                                            sst_pkg::E_OK);
                    cnt = cnt + 2'd1;
                    n_mode = sst_pkg::M_IDLE;
                end else if (b == sst_pkg::CH_LF) begin
                    n_line = line_inc(n_line);
                end
            end
            sst_pkg::M_LCOM: begin
                if (b == sst_pkg::CH_LF) begin
                    n_mode = sst_pkg::M_IDLE;
                    redo = 1'b1;
                end
            end
            sst_pkg::M_BCOM, sst_pkg::M_BSTAR: begin
                if (r_mode == sst_pkg::M_BSTAR && b == "/") n_mode = sst_pkg::M_IDLE;
                else if (b == "*") n_mode = sst_pkg::M_BSTAR;
                else begin
                    if (b == sst_pkg::CH_LF) n_line = line_inc(n_line);
                    n_mode = sst_pkg::M_BCOM;
                end
            end
            default: begin
            end
        endcase

        if (n_mode == sst_pkg::M_IDLE && (redo || r_mode == sst_pkg::M_IDLE)) begin
            n_so = pos;
            case (b)
                "(": begin ik = sst_pkg::K_LPAREN;   ik_ok = 1'b1; end
                ")": begin ik = sst_pkg::K_RPAREN;   ik_ok = 1'b1; end
                "[": begin ik = sst_pkg::K_LBRACK;   ik_ok = 1'b1; end
                "]": begin ik = sst_pkg::K_RBRACK;   ik_ok = 1'b1; end
                "{": begin ik = sst_pkg::K_LBRACE;   ik_ok = 1'b1; end
                "}": begin ik = sst_pkg::K_RBRACE;   ik_ok = 1'b1; end
                ".": begin ik = sst_pkg::K_DOT;      ik_ok = 1'b1; end
                ",": begin ik = sst_pkg::K_COMMA;    ik_ok = 1'b1; end
                ":": begin ik = sst_pkg::K_COLON;    ik_ok = 1'b1; end
                ";": begin ik = sst_pkg::K_SEMI;     ik_ok = 1'b1; end
                "~": begin ik = sst_pkg::K_TILDE;    ik_ok = 1'b1; end
                "?": begin ik = sst_pkg::K_QUESTION; ik_ok = 1'b1; end
                " ", sst_pkg::CH_TAB, sst_pkg::CH_CR: begin
                end
                sst_pkg::CH_LF: n_line = line_inc(n_line);
                "\"": n_mode = sst_pkg::M_STR;
                "+", "-", "*", "/", "%", "!", "&", "|", "^", "<", ">", "=": begin
                    n_pend = b;
                    n_mode = sst_pkg::M_OPER;
                end
                default: begin
                    if (sst_pkg::is_digit(b)) begin
                        n_mode = sst_pkg::M_NUMI;
                    end else if (sst_pkg::is_letter(b)) begin
                        n_mode = sst_pkg::M_WORD;
                        n_cand = sst_pkg::key_match(3'd0, b);
                        n_wl   = 3'd1;
                    end else begin
                        o_bundle.toks[cnt] = mk(sst_pkg::K_END, pos, end1, n_line,
                                                sst_pkg::E_UNKNOWN_CHAR);
                        cnt = cnt + 2'd1;
                        n_mode = sst_pkg::M_DROP;
                    end
                end
            endcase
            if (ik_ok) begin
                o_bundle.toks[cnt] = mk(ik, pos, end1, n_line, sst_pkg::E_OK);
                cnt = cnt + 2'd1;
            end
        end

        if (i_data.end_of_source) begin
            case (n_mode)
                sst_pkg::M_OPER: begin
                    o_bundle.toks[cnt] = mk(sst_pkg::single_kind(n_pend), n_so, end1, n_line,
                                            sst_pkg::E_OK);
                    cnt = cnt + 2'd1;
                end
                sst_pkg::M_NUMI, sst_pkg::M_NUMF: begin
                    o_bundle.toks[cnt] = mk(sst_pkg::K_NUMBER, n_so, end1, n_line,
                                            sst_pkg::E_OK);
                    cnt = cnt + 2'd1;
                end
                sst_pkg::M_NUMD: begin
                    o_bundle.toks[cnt] = mk(sst_pkg::K_END, n_so, end1, n_line,
                                            sst_pkg::E_NUMBER_DOT);
                    cnt = cnt + 2'd1;
                    ended = 1'b1;
                end
                sst_pkg::M_WORD: begin
                    o_bundle.toks[cnt] = mk(sst_pkg::word_kind(n_cand, n_wl), n_so, end1,
                                            n_line, sst_pkg::E_OK);
                    cnt = cnt + 2'd1;
                end
                sst_pkg::M_STR: begin
                    o_bundle.toks[cnt] = mk(sst_pkg::K_END, ofs_inc(n_so), end1, n_line,
                                            sst_pkg::E_UNTERM_STRING);
                    cnt = cnt + 2'd1;
                    ended = 1'b1;
                end
                sst_pkg::M_DROP: ended = 1'b1;
                default: begin
                end
            endcase
            if (!ended) begin
                o_bundle.toks[cnt] = mk(sst_pkg::K_END, end1, end1, n_line, sst_pkg::E_OK);
                cnt = cnt + 2'd1;
            end
            n_mode = sst_pkg::M_IDLE;
            n_pend = '0;
            n_so   = '0;
            n_ofs  = '0;
            n_line = LW'(1);
            n_wl   = '0;
            n_cand = '1;
        end
        o_bundle.count = cnt;
    end

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (o_bundle.count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sst_pkg::M_IDLE;
            r_pend <= '0;
            r_so   <= '0;
            r_ofs  <= '0;
            r_line <= LW'(1);
            r_wl   <= '0;
            r_cand <= '1;
        end else if (accept) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_so   <= n_so;
            r_ofs  <= n_ofs;
            r_line <= n_line;
            r_wl   <= n_wl;
            r_cand <= n_cand;
        end
    end
endmodule
`default_nettype wire

// ----- design/sst_queue.sv -----
// Short queue of token bundles between scanner and output stage
`timescale 1ns / 1ps
`default_nettype none
module sst_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  sst_pkg::t_bundle i_data,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_valid,
    output sst_pkg::t_bundle o_data
);
    localparam int unsigned PW = $clog2(sst_pkg::QUEUE_DEPTH);

    sst_pkg::t_bundle   r_mem [sst_pkg::QUEUE_DEPTH];
    logic [PW-1:0]      r_wp, r_rp;
    logic [PW:0]        r_cnt;

    assign o_full  = r_cnt == (PW+1)'(sst_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= PW'(r_wp + 1'b1);
            if (i_pop)  r_rp <= PW'(r_rp + 1'b1);
            r_cnt <= (PW+1)'(r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop));
        end
    end
endmodule
`default_nettype wire

// ----- design/sst_back.sv -----
// Output stage: hand out the tokens of each bundle one transaction at a time
`timescale 1ns / 1ps
`default_nettype none
module sst_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_q_valid,
    input  sst_pkg::t_bundle i_q_data,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output sst_pkg::t_out    o_data
);
    sst_pkg::t_bundle r_bun;
    logic [1:0]       r_idx;
    logic             r_have;
    logic             fire, last, free;

    assign last  = r_idx == 2'(r_bun.count - 2'd1);
    assign fire  = r_have && i_ready;
    assign free  = !r_have || (fire && last);
    assign o_pop = free && i_q_valid;

    always_comb begin
        o_data = r_bun.toks[r_idx];
        o_data.last_of_run = last;
    end
    assign o_valid = r_have;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_bun <= i_q_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_have <= 1'b1;
            r_idx  <= '0;
        end else if (free) begin
            r_have <= 1'b0;
        end else if (fire) begin
            r_idx <= 2'(r_idx + 2'd1);
        end
    end
endmodule
`default_nettype wire

// ----- design/script_source_tokenizer_unit.sv -----
// Top level of the streaming source tokenizer
//
// Input channel: one source byte per transaction, end_of_source set on the last
// byte of a text. Output channel: one token per transaction with kind, start,
// length, line, error code and a flag on the last token caused by a byte.
// The scanner takes one byte per cycle while the queue is not full and writes
// its tokens into a four-entry bundle queue; the output stage sends one token
// per cycle while the receiver is ready, one transfer for each token of a byte;
// a token is registered in the queue and then in the output register.
// A sustained byte rate of one per cycle holds while the receiver is ready and
// bytes average no more than one token each; the output stage port sets it.
// When the receiver stalls, tokens wait in the output register and the queue;
// input ready falls only once the queue is full.
// After the last byte an END token follows, or an error token ends the text,
// and the scanner returns to its reset state for the next source.
// Reset (synchronous, active low) empties the queue and clears scanner state:
// offset zero, line one.
`timescale 1ns / 1ps
`default_nettype none
module script_source_tokenizer_unit #(
    parameter int unsigned SOURCE_OFFSET_MAX = sst_pkg::SRC_OFS_MAX_DEF,
    parameter int unsigned LINE_COUNT_MAX    = sst_pkg::LINE_MAX_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  sst_pkg::t_in     i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output sst_pkg::t_out    o_out_data
);
    logic             q_full, q_push, q_pop, q_valid;
    sst_pkg::t_bundle f_bundle, q_data;

    sst_front #(
        .SOURCE_OFFSET_MAX (SOURCE_OFFSET_MAX),
        .LINE_COUNT_MAX    (LINE_COUNT_MAX)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_data   (i_in_data),
        .o_ready  (o_in_ready),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_bundle (f_bundle)
    );

    sst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_bundle),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    sst_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

`ifndef SYNTHESIS
    a_err_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error_code != sst_pkg::E_OK
        |-> o_out_data.token_kind == sst_pkg::K_END)
        else $error("error token without END kind");
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.token_kind == sst_pkg::K_END
        |-> o_out_data.last_of_run)
        else $error("END token not last of its run");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("push into full queue");
`endif
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench of the streaming source tokenizer
`timescale 1ns / 1ps
module testbench;
    import sst_pkg::*;

    localparam int unsigned OFS_MAX    = 65535;
    localparam int unsigned LINES_MAX  = 65535;
    localparam int unsigned CYCLE_CAP  = 400000;
    localparam int unsigned RAND_BYTES = 300;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       typed;
        t_out       want;
    } t_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_ready;
    t_out  o_out_data;

    script_source_tokenizer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    string kw [13] = '{"let", "if", "else", "true", "false", "nil", "while",
                       "for", "fn", "field", "return", "static", "const"};
    string ops [42] = '{"(", ")", "[", "]", "{", "}", ".", ",", ":", ";", "+", "+=",
                        "-", "-=", "*", "*=", "/", "/=", "%", "%=", "~", "!", "!=",
                        "&", "&&", "&=", "|", "||", "|=", "^", "^=", "<", "<=", "<<",
                        "<<=", ">", ">=", ">>", ">>=", "=", "==", "?"};

    // scanner image
    t_mode       mode;
    logic [7:0]  pend;
    int unsigned tok_begin;
    int unsigned ofs;
    int unsigned line;
    int unsigned wl;
    logic [12:0] cand;

    t_out  step_toks [$];
    t_out  expected_tokens [$];
    t_out  want;
    t_row  dir_tab [$];
    int    errors;
    int    bytes_sent;
    int    tokens_seen;
    int    in_idle;
    int    out_idle;
    int unsigned cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned sat(input int unsigned v, input int unsigned mx);
        return v < mx ? v + 1 : mx;
    endfunction

    function automatic logic dec_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic int punct(input logic [7:0] c);
        case (c)
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "[": return K_LBRACK;
            "]": return K_RBRACK;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            ".": return K_DOT;
            ",": return K_COMMA;
            ":": return K_COLON;
            ";": return K_SEMI;
            "~": return K_TILDE;
            "?": return K_QUESTION;
            default: return -1;
        endcase
    endfunction

    function automatic logic op_char(input logic [7:0] c);
        string s;
        s = "+-*/%!&|^<>=";
        for (int i = 0; i < s.len(); i++)
            if (s[i] == c) return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_kind lone_op(input logic [7:0] p);
        case (p)
            "+": return K_PLUS;
            "-": return K_MINUS;
            "*": return K_STAR;
            "/": return K_SLASH;
            "%": return K_PERCENT;
            "!": return K_BANG;
            "&": return K_AMP;
            "|": return K_PIPE;
            "^": return K_CARET;
            "<": return K_LT;
            "L": return K_SHL;
            ">": return K_GT;
            "G": return K_SHR;
            default: return K_ASSIGN;
        endcase
    endfunction

    function automatic int joined_op(input logic [7:0] p, input logic [7:0] c);
        if (p == "&" && c == "&") return K_AMP_AMP;
        if (p == "|" && c == "|") return K_PIPE_PIPE;
        if (c != "=") return -1;
        if (p == "&") return K_AMP_EQ;
        if (p == "|") return K_PIPE_EQ;
        return int'(lone_op(p)) + 1;
    endfunction

    function automatic t_kind word_token();
        for (int k = 0; k < 13; k++)
            if (cand[k] && kw[k].len() == wl) return t_kind'(int'(K_LET) + k);
        return K_IDENT;
    endfunction

    task automatic put(input t_kind k, input int unsigned s, input int unsigned e,
                       input t_err er);
        t_out t;
        if (step_toks.size() < 3) begin
            t.token_kind   = k;
            t.token_start  = s[15:0];
            t.token_length = (e >= s) ? 16'(e - s) : 16'd0;
            t.line_number  = line[15:0];
            t.error_code   = er;
            t.last_of_run  = 1'b0;
            step_toks.push_back(t);
        end
    endtask

    task automatic feed(input logic [7:0] c);
        logic [12:0] m;
        m = '0;
        for (int k = 0; k < 13; k++)
            if (wl < kw[k].len() && kw[k][wl] == c) m[k] = 1'b1;
        cand &= m;
        wl = wl < 7 ? wl + 1 : 7;
    endtask

    task automatic clear_scanner();
        mode = M_IDLE; pend = '0; tok_begin = 0; ofs = 0; line = 1; wl = 0; cand = '1;
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic eos);
        int unsigned pos, end1;
        int pk;
        logic redo, ended;
        step_toks = {};
        pos = ofs;
        end1 = sat(pos, OFS_MAX);
        redo = 1'b1;
        while (redo) begin
            redo = 1'b0;
            case (mode)
                M_IDLE: begin
                    tok_begin = pos;
                    pk = punct(b);
                    if (pk >= 0) put(t_kind'(pk), pos, end1, E_OK);
                    else if (b == " " || b == CH_TAB || b == CH_CR) ;
                    else if (b == CH_LF) line = sat(line, LINES_MAX);
                    else if (b == "\"") mode = M_STR;
                    else if (op_char(b)) begin
                        pend = b;
                        mode = M_OPER;
                    end else if (dec_digit(b)) mode = M_NUMI;
                    else if (word_char(b)) begin
                        mode = M_WORD; wl = 0; cand = '1;
                        feed(b);
                    end else begin
                        put(K_END, pos, end1, E_UNKNOWN_CHAR);
                        mode = M_DROP;
                    end
                end
                M_OPER: begin
                    if (pend == "/" && b == "/") mode = M_LCOM;
                    else if (pend == "/" && b == "*") mode = M_BCOM;
                    else if (pend == "<" && b == "<") pend = "L";
                    else if (pend == ">" && b == ">") pend = "G";
                    else begin
                        pk = joined_op(pend, b);
                        mode = M_IDLE;
                        if (pk >= 0) put(t_kind'(pk), tok_begin, end1, E_OK);
                        else begin
                            put(lone_op(pend), tok_begin, pos, E_OK);
                            redo = 1'b1;
                        end
                    end
                end
                M_NUMI, M_NUMF: begin
                    if (dec_digit(b)) ;
                    else if (mode == M_NUMI && b == ".") mode = M_NUMD;
                    else begin
                        put(K_NUMBER, tok_begin, pos, E_OK);
                        mode = M_IDLE;
                        redo = 1'b1;
                    end
                end
                M_NUMD: begin
                    if (dec_digit(b)) mode = M_NUMF;
                    else begin
                        put(K_END, tok_begin, pos, E_NUMBER_DOT);
                        mode = M_DROP;
                    end
                end
                M_WORD: begin
                    if (word_char(b) || dec_digit(b)) feed(b);
                    else begin
                        put(word_token(), tok_begin, pos, E_OK);
                        mode = M_IDLE;
                        redo = 1'b1;
                    end
                end
                M_STR: begin
                    if (b == "\"") begin
                        put(K_STRING, sat(tok_begin, OFS_MAX), pos, E_OK);
                        mode = M_IDLE;
                    end else if (b == CH_LF) line = sat(line, LINES_MAX);
                end
                M_LCOM: begin
                    if (b == CH_LF) begin
                        mode = M_IDLE;
                        redo = 1'b1;
                    end
                end
                M_BCOM, M_BSTAR: begin
                    if (mode == M_BSTAR && b == "/") mode = M_IDLE;
                    else if (b == "*") mode = M_BSTAR;
                    else begin
                        if (b == CH_LF) line = sat(line, LINES_MAX);
                        mode = M_BCOM;
                    end
                end
                default: mode = M_DROP;
            endcase
        end
        if (eos) begin
            ended = 1'b0;
            case (mode)
                M_OPER: put(lone_op(pend), tok_begin, end1, E_OK);
                M_NUMI, M_NUMF: put(K_NUMBER, tok_begin, end1, E_OK);
                M_NUMD: begin
                    put(K_END, tok_begin, end1, E_NUMBER_DOT);
                    ended = 1'b1;
                end
                M_WORD: put(word_token(), tok_begin, end1, E_OK);
                M_STR: begin
                    put(K_END, sat(tok_begin, OFS_MAX), end1, E_UNTERM_STRING);
                    ended = 1'b1;
                end
                M_DROP: ended = 1'b1;
                default: ;
            endcase
            if (!ended) put(K_END, end1, end1, E_OK);
            clear_scanner();
        end else begin
            ofs = end1;
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                             input t_out texp);
        while ($urandom_range(99) < in_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{source_byte: b, end_of_source: eos};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        scan_byte(b, eos);
        if (typed) expected_tokens.push_back(texp);
        else foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1, 1'b0, '0);
    endtask

    task automatic add_row(input logic [7:0] c, input logic eos, input logic typed,
                           input t_out w);
        dir_tab.push_back('{ch: c, eos: eos, typed: typed, want: w});
    endtask

    function automatic string rand_word(input int n);
        string s, pool;
        pool = "abcdefilnorstuwxyzAZ_09";
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(pool[$urandom_range(i == 0 ? 20 : 22, 0)])};
        return s;
    endfunction

    function automatic string rand_source();
        string s, f;
        int n;
        s = "";
        n = $urandom_range(12, 1);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1: f = ops[$urandom_range(41)];
                2: f = kw[$urandom_range(12)];
                3: f = rand_word($urandom_range(9, 1));
                4: f = $urandom_range(1) ? $sformatf("%0d.%0d", $urandom_range(999),
                                                      $urandom_range(99))
                                         : $sformatf("%0d", $urandom_range(99999));
                5: f = {"\"", rand_word($urandom_range(5)),
                        $urandom_range(3) == 0 ? "\n" : "", "\""};
                6: f = $urandom_range(1) ? "\n" : "\t\r ";
                7: f = $urandom_range(1) ? {"//", rand_word(3), "\n"}
                                         : {"/*", rand_word(2), "*", "\n*/"};
                8: f = $urandom_range(3) == 0 ? string'(8'($urandom_range(255))) : " ";
                default: f = {kw[$urandom_range(12)], rand_word($urandom_range(2))};
            endcase
            if ($urandom_range(5) == 0) f = f.substr(0, f.len() - 2);
            s = {s, f, $urandom_range(1) ? " " : ""};
        end
        if (s.len() == 0) s = " ";
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= out_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t: token with none expected: actual %p", $time, o_out_data);
            end else begin
                want = expected_tokens.pop_front();
                if (o_out_data !== want) begin
                    errors++;
                    $display("%0t: token mismatch: expected %p actual %p",
                             $time, want, o_out_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int target;
        string src;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_data = '0; i_out_ready = 1'b0;
        errors = 0; bytes_sent = 0; tokens_seen = 0; cycles = 0;
        in_idle = 28; out_idle = 88;
        clear_scanner();
        add_row("@", 1, 1, '{K_END, 16'd0, 16'd1, 16'd1, E_UNKNOWN_CHAR, 1'b1});
        add_row("1", 0, 0, '0);
        add_row(".", 1, 1, '{K_END, 16'd0, 16'd2, 16'd1, E_NUMBER_DOT, 1'b1});
        add_row("\"", 0, 0, '0);
        add_row("a", 1, 1, '{K_END, 16'd1, 16'd1, 16'd1, E_UNTERM_STRING, 1'b1});
        add_row("%", 0, 0, '0);
        add_row("=", 0, 0, '0);
        add_row("<", 0, 0, '0);
        add_row("<", 0, 0, '0);
        add_row("=", 0, 0, '0);
        add_row("/", 0, 0, '0);
        add_row("*", 0, 0, '0);
        add_row("/", 0, 0, '0);
        add_row("*", 0, 0, '0);
        add_row("/", 0, 0, '0);
        add_row("/", 0, 0, '0);
        add_row("/", 0, 0, '0);
        add_row(CH_LF, 0, 0, '0);
        add_row("9", 0, 0, '0);
        add_row(".", 0, 0, '0);
        add_row("5", 0, 0, '0);
        add_row(8'hFF, 0, 0, '0);
        add_row("x", 1, 0, '0);
        add_row("/", 0, 0, '0);
        add_row("*", 0, 0, '0);
        add_row(8'h00, 1, 0, '0);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_tab[i])
            send_byte(dir_tab[i].ch, dir_tab[i].eos, dir_tab[i].typed, dir_tab[i].want);
        for (int ph = 0; ph < 3; ph++) begin
            in_idle  = (ph == 0) ? 28 : (ph == 1) ? 88 : 0;
            out_idle = (ph == 0) ? 88 : (ph == 1) ? 28 : 0;
            target = bytes_sent + RAND_BYTES / 3;
            while (bytes_sent < target) begin
                src = rand_source();
                send_text(src);
            end
        end
        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d source bytes and checked %0d tokens over three idling mixes,",
                 bytes_sent, tokens_seen);
        $display("including errors, comments, operators, strings and keywords.");
        if (errors == 0 && expected_tokens.size() == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
